/* hw/rtl/sss_pkg.sv */
// Package for the stepper step scheduler: widths, register map, reset values
// and the state type of the interval sequencer. Depends on nothing.
package sss_pkg;

	localparam int TIME_W     = 32;
	localparam int SPEED_W    = 10;
	localparam int INTERVAL_W = 20;
	localparam int US_W       = 20;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Register indexes, taken from paddr[2].
	localparam logic REG_SPEED_RPM = 1'b0;

	localparam logic [SPEED_W-1:0]    SPEED_RESET    = 10'd300;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 20'd1000;
	localparam logic [INTERVAL_W-1:0] INTERVAL_MAX   = 20'd1048575;
	localparam logic [US_W-1:0]       US_PER_SEC     = 20'd1000000;
	localparam int                    SECONDS_PER_MIN = 60;

	// Division by fifteen as a multiply by the rounded-up reciprocal 2^28/15
	// and a right shift by 28. It is exact for every operand below 2^24.
	localparam logic [24:0]           RECIP15_MUL    = 25'd17895698;
	localparam int                    RECIP15_SHIFT  = 28;

	typedef enum logic [2:0] {
		IS_IDLE,
		IS_MUL,
		IS_SPS,
		IS_INT_START,
		IS_INT_WAIT
	} int_state_t;

	typedef struct packed {
		logic               wr;
		logic [SPEED_W-1:0] rpm;
	} cfg_wr_t;

endpackage

/* hw/rtl/sss_divider.sv */
// Restoring divider, one quotient bit per cycle, used by the interval sequencer.
// Depends on nothing.
module sss_divider #(
	parameter int W = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dvs_q;

	logic [W:0]   shifted;
	logic [W:0]   diff;
	logic         take;

	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		diff    = shifted - {1'b0, dvs_q};
		take    = (shifted >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hw/rtl/sss_interval.sv */
// Speed register and the sequencer that turns it into a step interval.
// Depends on sss_pkg and sss_divider.
module sss_interval #(
	parameter int STEPS_PER_TURN = 200,
	parameter int MIN_RPM        = 1,
	parameter int MAX_RPM        = 1000
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sss_pkg::cfg_wr_t                 cfg,
	output logic [sss_pkg::SPEED_W-1:0]      speed_rpm,
	output logic [sss_pkg::INTERVAL_W-1:0]   interval,
	output logic                             busy
);

	localparam int SPR_W  = $clog2(STEPS_PER_TURN + 1);
	localparam int PROD_W = $clog2(MAX_RPM * STEPS_PER_TURN + 1);
	localparam int DIV_W  = (PROD_W > sss_pkg::US_W) ? PROD_W : sss_pkg::US_W;
	localparam int RECIP_PROD_W = PROD_W + $bits(sss_pkg::RECIP15_MUL);

	localparam logic [sss_pkg::SPEED_W-1:0] RpmLo = sss_pkg::SPEED_W'(MIN_RPM);
	localparam logic [sss_pkg::SPEED_W-1:0] RpmHi = sss_pkg::SPEED_W'(MAX_RPM);
	localparam logic [SPR_W-1:0]            Spr   = SPR_W'(STEPS_PER_TURN);

	sss_pkg::int_state_t state_q, state_d;

	logic [sss_pkg::SPEED_W-1:0]    rpm_q;
	logic [PROD_W-1:0]              prod_q;
	logic [DIV_W-1:0]               sps_q;
	logic [sss_pkg::INTERVAL_W-1:0] interval_q;

	logic [sss_pkg::SPEED_W-1:0]       rpm_lo;
	logic [sss_pkg::SPEED_W-1:0]       rpm_clamp;
	logic [sss_pkg::SPEED_W+SPR_W-1:0] prod_full;
	logic [RECIP_PROD_W-1:0]           recip_prod;
	logic [DIV_W-1:0]                  sps_next;

	logic             div_start;
	logic [DIV_W-1:0] div_dividend;
	logic [DIV_W-1:0] div_divisor;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;

	always_comb begin
		rpm_lo    = (rpm_q < RpmLo) ? RpmLo : rpm_q;
		rpm_clamp = (rpm_lo > RpmHi) ? RpmHi : rpm_lo;
		prod_full = rpm_clamp * Spr;
		// Steps per second is the product over sixty: drop two bits, then divide
		// by fifteen through the reciprocal. The product stays below 2^26.
		recip_prod = RECIP_PROD_W'(prod_q >> 2) * RECIP_PROD_W'(sss_pkg::RECIP15_MUL);
		sps_next   = DIV_W'(recip_prod >> sss_pkg::RECIP15_SHIFT);
	end

	sss_divider #(.W(DIV_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = DIV_W'(sss_pkg::US_PER_SEC);
		div_divisor  = sps_q;
		unique case (state_q)
			sss_pkg::IS_IDLE: ;
			sss_pkg::IS_MUL: state_d = sss_pkg::IS_SPS;
			sss_pkg::IS_SPS: state_d = sss_pkg::IS_INT_START;
			sss_pkg::IS_INT_START: begin
				if (sps_q == '0) begin
					state_d = sss_pkg::IS_IDLE;
				end else begin
					div_start = 1'b1;
					state_d   = sss_pkg::IS_INT_WAIT;
				end
			end
			sss_pkg::IS_INT_WAIT: begin
				if (div_done) state_d = sss_pkg::IS_IDLE;
			end
			default: state_d = sss_pkg::IS_IDLE;
		endcase
		// A new speed restarts the computation from the top.
		if (cfg.wr) state_d = sss_pkg::IS_MUL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sss_pkg::IS_IDLE;
			rpm_q      <= sss_pkg::SPEED_RESET;
			interval_q <= sss_pkg::INTERVAL_RESET;
		end else begin
			state_q <= state_d;
			if (cfg.wr) rpm_q <= cfg.rpm;
			if (state_q == sss_pkg::IS_INT_START && sps_q == '0 && !cfg.wr) begin
				interval_q <= sss_pkg::INTERVAL_MAX;
			end else if (state_q == sss_pkg::IS_INT_WAIT && div_done && !cfg.wr) begin
				interval_q <= (div_quo > DIV_W'(sss_pkg::INTERVAL_MAX)) ?
					sss_pkg::INTERVAL_MAX : div_quo[sss_pkg::INTERVAL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sss_pkg::IS_MUL) prod_q <= prod_full[PROD_W-1:0];
		if (state_q == sss_pkg::IS_SPS) sps_q <= sps_next;
	end

	assign speed_rpm = rpm_q;
	assign interval  = interval_q;
	assign busy      = (state_q != sss_pkg::IS_IDLE);

endmodule

/* hw/rtl/sss_tracker.sv */
// Update pipeline: input stage, position and step-time state, result register.
// Depends on sss_pkg.
module sss_tracker #(
	parameter int POSITION_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             hold,
	input  logic [sss_pkg::INTERVAL_W-1:0]   interval,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [sss_pkg::TIME_W-1:0]       now_us,
	input  logic [POSITION_BITS-1:0]         target_position,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             step_pulse,
	output logic                             dir_ccw,
	output logic [POSITION_BITS-1:0]         position,
	output logic                             at_target
);

	logic                          valid_s1;
	logic [sss_pkg::TIME_W-1:0]    now_s1;
	logic [POSITION_BITS-1:0]      target_s1;

	logic [POSITION_BITS-1:0]      cur_q;
	logic [sss_pkg::TIME_W-1:0]    last_q;

	logic                          out_valid_q;
	logic                          pulse_q;
	logic                          dir_q;
	logic [POSITION_BITS-1:0]      pos_q;
	logic                          at_q;

	logic                          out_free;
	logic                          move;
	logic                          accept;
	logic                          dir;
	logic                          fire;
	logic [sss_pkg::TIME_W-1:0]    elapsed;
	logic [POSITION_BITS-1:0]      cur_next;

	always_comb begin
		out_free = !out_valid_q || !out_stall;
		move     = valid_s1 && out_free;
		in_stall = hold || (valid_s1 && !out_free);
		accept   = in_valid && !in_stall;

		dir      = !(target_s1 > cur_q);
		elapsed  = now_s1 - last_q;
		fire     = (cur_q != target_s1) &&
			(elapsed >= sss_pkg::TIME_W'(interval));
		cur_next = cur_q;
		if (fire) begin
			if (!dir) begin
				if (cur_q != '1) cur_next = cur_q + POSITION_BITS'(1);
			end else begin
				if (cur_q != '0) cur_next = cur_q - POSITION_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			cur_q       <= '0;
			last_q      <= '0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (move) valid_s1 <= 1'b0;
			if (move) out_valid_q <= 1'b1;
			else if (out_free) out_valid_q <= 1'b0;
			if (move) begin
				cur_q <= cur_next;
				if (fire) last_q <= now_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_s1    <= now_us;
			target_s1 <= target_position;
		end
		if (move) begin
			pulse_q <= fire;
			dir_q   <= dir;
			pos_q   <= cur_next;
			at_q    <= (cur_next == target_s1);
		end
	end

	assign out_valid  = out_valid_q;
	assign step_pulse = pulse_q;
	assign dir_ccw    = dir_q;
	assign position   = pos_q;
	assign at_target  = at_q;

endmodule

/* hw/rtl/stepper_step_scheduler.sv */
// Top level of the stepper step scheduler: configuration port, interval
// sequencer and update pipeline. Depends on sss_pkg, sss_interval, sss_tracker.
//
// Usage:
// The input channel (in_valid, in_stall, now_us, target_position) carries one
// update per transfer: the current time in microseconds and the wanted position.
// The output channel (out_valid, out_stall, step_pulse, dir_ccw, position,
// at_target) returns exactly one result per update, in order.
// An accepted update is registered in the input stage, and its result moves
// into the output register once that register is free. Throughput is one
// update per cycle while the receiver does not stall and the sequencer is
// idle; the position and last-step-time registers are read and written in
// the same cycle as the update moves to the output register.
// When the receiver stalls, the result holds in the output register and one
// more update waits in the input stage; only then does the stall reach in_stall.
// The APB port holds speed_rpm at address 0. A write starts the interval
// sequencer: a state for the speed times steps-per-revolution product, a
// state for the division by sixty as a reciprocal multiplication, then one
// pass of a one-bit-per-cycle divider for one million by steps per second.
// The input channel stalls while the sequencer is busy after the write.
// Reset clears the position and last step time to zero, sets speed to 300 rpm
// and the interval to 1000 microseconds, and empties both stages.
module stepper_step_scheduler #(
	parameter int STEPS_PER_TURN = 200,
	parameter int MIN_RPM        = 1,
	parameter int MAX_RPM        = 1000,
	parameter int POSITION_BITS  = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [sss_pkg::TIME_W-1:0]         now_us,
	input  logic [POSITION_BITS-1:0]           target_position,

	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               step_pulse,
	output logic                               dir_ccw,
	output logic [POSITION_BITS-1:0]           position,
	output logic                               at_target,

	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [sss_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [sss_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [sss_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);

	sss_pkg::cfg_wr_t                 cfg;
	logic [sss_pkg::SPEED_W-1:0]      speed_rpm;
	logic [sss_pkg::INTERVAL_W-1:0]   interval;
	logic                             busy;

	// Only the speed register exists; a transfer to any other index is dropped.
	// Bits of the written word above the register width are ignored.
	always_comb begin
		cfg.wr  = psel && penable && pwrite && (paddr[2] == sss_pkg::REG_SPEED_RPM);
		cfg.rpm = pwdata[sss_pkg::SPEED_W-1:0];
		unique case (paddr[2])
			sss_pkg::REG_SPEED_RPM: prdata = sss_pkg::APB_DATA_W'(speed_rpm);
			default:                prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	sss_interval #(
		.STEPS_PER_TURN (STEPS_PER_TURN),
		.MIN_RPM        (MIN_RPM),
		.MAX_RPM        (MAX_RPM)
	) u_interval (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.speed_rpm (speed_rpm),
		.interval  (interval),
		.busy      (busy)
	);

	// Updates are held off while a new interval is being computed.
	sss_tracker #(
		.POSITION_BITS (POSITION_BITS)
	) u_tracker (
		.clk             (clk),
		.arst_n          (arst_n),
		.hold            (busy),
		.interval        (interval),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.now_us          (now_us),
		.target_position (target_position),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.step_pulse      (step_pulse),
		.dir_ccw         (dir_ccw),
		.position        (position),
		.at_target       (at_target)
	);

endmodule

/* hw/rtl/sss_checker.sv */
// Port-level checks for the stepper step scheduler, bound to the top level.
// Depends on stepper_step_scheduler.
module sss_checker #(
	parameter int POSITION_BITS = 24
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic                     step_pulse,
	input logic                     dir_ccw,
	input logic [POSITION_BITS-1:0] position,
	input logic                     at_target
);

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(position) && $stable(step_pulse)
			&& $stable(dir_ccw) && $stable(at_target))
		else $error("result changed while stalled");

	// An upward step always leaves the position above zero.
	a_up_step_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_pulse && !dir_ccw |-> position != '0)
		else $error("upward step reported position zero");

	// Upward direction without a step means the target is still above.
	a_up_wait_not_there: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !step_pulse && !dir_ccw |-> !at_target)
		else $error("at target reported while still below it");

endmodule

bind stepper_step_scheduler sss_checker #(.POSITION_BITS(POSITION_BITS)) u_sss_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.step_pulse (step_pulse),
	.dir_ccw    (dir_ccw),
	.position   (position),
	.at_target  (at_target)
);
